// ===== sv/mcfh_pkg.sv =====
// shared constants, types and the crc-8 byte step for the motor command frame handler
// no dependencies; imported by mcfh_crc8 and motor_command_frame_handler
package mcfh_pkg;

  localparam int unsigned MOTOR_COUNT = 4;
  localparam int unsigned MOTOR_W     = $clog2(MOTOR_COUNT);
  localparam int unsigned RESP_LEN    = 1 + 4 * MOTOR_COUNT;
  localparam int unsigned CNT_W       = $clog2(RESP_LEN);

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_INIT  = 8'hFF;
  localparam logic [7:0] STATUS_OK = 8'h00;

  localparam logic [7:0] OP_SET_SPEED = 8'h01;
  localparam logic [7:0] OP_STOP      = 8'h02;
  localparam logic [7:0] OP_EMERGENCY = 8'h03;
  localparam logic [7:0] OP_TELEMETRY = 8'h10;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_GAP   = 2'd1,
    ACT_TELEM = 2'd2,
    ACT_RSVD  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SETPOINT  = 3'd1,
    EV_STOPPED   = 3'd2,
    EV_EMERGENCY = 3'd3,
    EV_BAD_ID    = 3'd4,
    EV_TELEMETRY = 3'd5,
    EV_UNKNOWN   = 3'd6
  } event_e;

  typedef struct packed {
    logic       done;
    logic [7:0] crc;
  } crc_res_t;

  // one byte through the msb-first crc-8 register
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/motor_command_frame_handler.sv =====
// motor command frame handler: frame check, command decode, telemetry response sequencer
// depends on mcfh_pkg and mcfh_crc8
//
// One input transfer is one exchange period. A command frame (action 0) is checked with
// crc-8 (poly 0x07, init 0xFF, msb first) over cmd, motor id and the two setpoint bytes,
// one byte per cycle in mcfh_crc8; a mismatch drops the frame with no output. A good frame,
// or a period without a frame (action 1), produces a run of 17 output transfers: status
// 0x00, then the four rpm words, then the four current words, each big-endian. The command
// outcome (event, stop mask, setpoint motor and value) rides on the first byte of the run
// only; running_o holds on every byte and drops for good after an emergency stop, after
// which every input is taken and ignored until reset. A telemetry update (action 2) writes
// the rpm and current of one motor into the telemetry memory and gives no output. The
// setpoint of a frame is reported on setpoint_value_o and not kept on chip. The telemetry
// memory is a 4 x 32-bit synchronous ram with a registered read port plus one valid bit
// per entry, so entries read as zero until first written. Inputs are taken only while the
// sequencer is idle, so writes and response reads never meet on the same entry. Each
// response word passes through a read state and a load state before its two bytes go out,
// which sets the pace. A good frame first waits for the crc walk in mcfh_crc8.
module motor_command_frame_handler import mcfh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         cmd_code_i,
  input  logic [7:0]         motor_index_i,
  input  logic [7:0]         setpoint_high_i,
  input  logic [7:0]         setpoint_low_i,
  input  logic [7:0]         frame_crc_i,
  input  logic signed [15:0] rpm_value_i,
  input  logic signed [15:0] current_value_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         resp_byte_o,
  output logic               last_byte_o,
  output logic [2:0]         event_code_o,
  output logic [3:0]         stop_mask_o,
  output logic [1:0]         setpoint_motor_o,
  output logic signed [15:0] setpoint_value_o,
  output logic               running_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for an input transfer
    S_CRC  = 5'b00010,  // crc walk over the frame bytes
    S_RD   = 5'b00100,  // telemetry memory read issued
    S_LD   = 5'b01000,  // read data back, load high byte
    S_SEND = 5'b10000   // output register holds a byte
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;   // index of the byte in the output register
  logic             en_q, en_d;     // enabled flag, cleared by emergency stop
  logic             ov_q, ov_d;     // output register full

  // captured frame
  logic [7:0] op_q, id_q, hi_q, lo_q, rx_q;

  // telemetry memory, {rpm, current} per motor
  logic [31:0]            tmem_q [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] tvld_q;
  logic [31:0]            rdata_q;
  logic                   rvalid_q;

  // output register payload
  logic [7:0]             resp_q;
  logic                   last_q;
  event_e                 ev_q;
  logic [MOTOR_COUNT-1:0] mask_q;
  logic [MOTOR_W-1:0]     sm_q;
  logic signed [15:0]     sv_q;

  logic in_fire, out_fire;
  logic crc_start, tel_we, rd_en, load_first, first_gap, load_byte;
  crc_res_t crc_res;

  // decoded command outcome
  event_e                 dec_ev;
  logic [MOTOR_COUNT-1:0] dec_mask;
  logic [MOTOR_W-1:0]     dec_sm;
  logic signed [15:0]     dec_sv;
  logic                   id_ok;

  // response word addressing: byte b (1..16) lives in word b-1 >> 1
  logic [CNT_W-1:0]   cnt_m1;
  logic [MOTOR_W-1:0] rd_motor;
  logic               rd_half;
  logic [15:0]        word16;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = ov_q & out_ready_i;

  mcfh_crc8 u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crc_start),
    .frame_i ({op_q, id_q, hi_q, lo_q}),
    .res_o   (crc_res)
  );

  // command decode from the captured frame
  assign id_ok = (id_q[7:MOTOR_W] == '0);

  always_comb begin
    dec_ev   = EV_UNKNOWN;
    dec_mask = '0;
    dec_sm   = '0;
    dec_sv   = '0;
    case (op_q)
      OP_SET_SPEED: begin
        if (id_ok) begin
          dec_ev = EV_SETPOINT;
          dec_sm = id_q[MOTOR_W-1:0];
          dec_sv = {hi_q, lo_q};
        end else begin
          dec_ev = EV_BAD_ID;
        end
      end
      OP_STOP: begin
        if (id_ok) begin
          dec_ev   = EV_STOPPED;
          dec_sm   = id_q[MOTOR_W-1:0];
          dec_mask = {{(MOTOR_COUNT-1){1'b0}}, 1'b1} << id_q[MOTOR_W-1:0];
        end else begin
          dec_ev = EV_BAD_ID;
        end
      end
      OP_EMERGENCY: begin
        dec_ev   = EV_EMERGENCY;
        dec_mask = '1;
      end
      OP_TELEMETRY: begin
        dec_ev = EV_TELEMETRY;
      end
      default: begin
        dec_ev = EV_UNKNOWN;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    en_d       = en_q;
    ov_d       = ov_q;
    crc_start  = 1'b0;
    tel_we     = 1'b0;
    rd_en      = 1'b0;
    load_first = 1'b0;
    first_gap  = 1'b0;
    load_byte  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && en_q) begin
          case (action_e'(action_i))
            ACT_FRAME: begin
              crc_start = 1'b1;
              state_d   = S_CRC;
            end
            ACT_GAP: begin
              load_first = 1'b1;
              first_gap  = 1'b1;
              cnt_d      = '0;
              ov_d       = 1'b1;
              state_d    = S_SEND;
            end
            ACT_TELEM: begin
              tel_we = (motor_index_i[7:MOTOR_W] == '0);
            end
            default: begin
            end
          endcase
        end
      end
      S_CRC: begin
        if (crc_res.done) begin
          if (crc_res.crc == rx_q) begin
            load_first = 1'b1;
            cnt_d      = '0;
            ov_d       = 1'b1;
            state_d    = S_SEND;
            if (op_q == OP_EMERGENCY) begin
              en_d = 1'b0;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        load_byte = 1'b1;
        ov_d      = 1'b1;
        state_d   = S_SEND;
      end
      S_SEND: begin
        if (out_fire) begin
          if (cnt_q == CNT_W'(RESP_LEN - 1)) begin
            ov_d    = 1'b0;
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (!cnt_q[0]) begin
              // next byte opens a new word
              ov_d    = 1'b0;
              state_d = S_RD;
            end else begin
              load_byte = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      en_q     <= 1'b1;
      ov_q     <= 1'b0;
      tvld_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      en_q    <= en_d;
      ov_q    <= ov_d;
      if (tel_we) begin
        tvld_q[motor_index_i[MOTOR_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= tvld_q[rd_motor];
      end
    end
  end

  // telemetry memory, one write and one registered read port
  assign cnt_m1   = cnt_q - 1'b1;
  assign rd_motor = cnt_m1[MOTOR_W:1];
  assign rd_half  = cnt_m1[MOTOR_W+1];

  always_ff @(posedge clk_i) begin
    if (tel_we) begin
      tmem_q[motor_index_i[MOTOR_W-1:0]] <= {rpm_value_i, current_value_i};
    end
    if (rd_en) begin
      rdata_q <= tmem_q[rd_motor];
    end
  end

  // unwritten entries read as zero
  assign word16 = !rvalid_q ? 16'h0000 : (rd_half ? rdata_q[15:0] : rdata_q[31:16]);

  // frame capture and output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= cmd_code_i;
      id_q <= motor_index_i;
      hi_q <= setpoint_high_i;
      lo_q <= setpoint_low_i;
      rx_q <= frame_crc_i;
    end
    if (load_first) begin
      resp_q <= STATUS_OK;
      last_q <= 1'b0;
      ev_q   <= first_gap ? EV_NONE : dec_ev;
      mask_q <= first_gap ? '0 : dec_mask;
      sm_q   <= first_gap ? '0 : dec_sm;
      sv_q   <= first_gap ? '0 : dec_sv;
    end else if (load_byte) begin
      resp_q <= (state_q == S_LD) ? word16[15:8] : word16[7:0];
      last_q <= (cnt_d == CNT_W'(RESP_LEN - 1));
      ev_q   <= EV_NONE;
      mask_q <= '0;
      sm_q   <= '0;
      sv_q   <= '0;
    end
  end

  assign out_valid_o      = ov_q;
  assign resp_byte_o      = resp_q;
  assign last_byte_o      = last_q;
  assign event_code_o     = ev_q;
  assign stop_mask_o      = mask_q;
  assign setpoint_motor_o = sm_q;
  assign setpoint_value_o = sv_q;
  assign running_o        = en_q;

`ifndef SYNTH
  // a full output register only exists while a byte is being sent
  a_ov_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_SEND)
    else $error("output valid outside send state");

  // command outcome only on the first byte of a run
  a_event_first_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cnt_q != '0) |-> (event_code_o == EV_NONE && stop_mask_o == '0))
    else $error("event fields on a later byte");

  // last flag lines up with the byte count
  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_byte_o) |-> cnt_q == CNT_W'(RESP_LEN - 1))
    else $error("last byte flag at wrong position");

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_q |=> !en_q)
    else $error("block left halt without reset");

  // crc result only arrives while waiting for it
  a_crc_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_res.done |-> state_q == S_CRC)
    else $error("crc done outside crc state");
`endif

endmodule

// ===== sv/mcfh_crc8.sv =====
// iterative crc-8 checker, one frame byte per cycle, byte 0 first
// depends on mcfh_pkg
module mcfh_crc8 import mcfh_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [31:0]     frame_i,
  output crc_res_t        res_o
);

  logic [7:0] acc_q, acc_d;
  logic [1:0] cnt_q;
  logic       busy_q;
  logic       done_q;
  logic [7:0] cur_byte;

  always_comb begin
    case (cnt_q)
      2'd0:    cur_byte = frame_i[31:24];
      2'd1:    cur_byte = frame_i[23:16];
      2'd2:    cur_byte = frame_i[15:8];
      default: cur_byte = frame_i[7:0];
    endcase
    acc_d = crc8_byte(acc_q, cur_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= 2'd0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= CRC_INIT;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.crc  = acc_q;

endmodule
